@@ hw/rtl/rotary_encoder_key_events_unit_macros.svh @@
// Assertion helpers for the RTL of the rotary encoder event unit.
`ifndef ROTARY_ENCODER_KEY_EVENTS_UNIT_MACROS_SVH
`define ROTARY_ENCODER_KEY_EVENTS_UNIT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define REK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define REK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/rek_pkg.sv @@
`default_nettype none

package rek_pkg;

  typedef enum logic [3:0] {
    EV_CW       = 4'd0,
    EV_CCW      = 4'd1,
    EV_FAST_CW  = 4'd2,
    EV_FAST_CCW = 4'd3,
    EV_KEY_CW   = 4'd4,
    EV_KEY_CCW  = 4'd5,
    EV_SINGLE   = 4'd6,
    EV_DOUBLE   = 4'd7,
    EV_LONG     = 4'd8
  } ev_code_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FAST_STEP     = 3'd0;
  localparam logic [2:0] CFG_BIG_STEP      = 3'd1;
  localparam logic [2:0] CFG_BIG_STEP_EN   = 3'd2;
  localparam logic [2:0] CFG_FAST_WINDOW   = 3'd3;
  localparam logic [2:0] CFG_HOLD          = 3'd4;
  localparam logic [2:0] CFG_DOUBLE_WINDOW = 3'd5;
  localparam logic [2:0] CFG_SINGLE_MAX    = 3'd6;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic        key_down;
    logic        chan_a;
    logic        chan_b;
    logic        ms_tick;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         event_code;
    logic signed [15:0] position;
    logic [15:0]        click_ms;
  } out_item_t;

  typedef struct packed {
    logic [15:0] fast_step;
    logic [15:0] big_step;
    logic        big_step_enable;
    logic [7:0]  fast_window_ms;
    logic [15:0] hold_ms;
    logic [15:0] double_window_ms;
    logic [15:0] single_max_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    fast_step:        16'd10,
    big_step:         16'd100,
    big_step_enable:  1'b1,
    fast_window_ms:   8'd30,
    hold_ms:          16'd3000,
    double_window_ms: 16'd380,
    single_max_ms:    16'd230
  };

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rek_core.sv @@
`default_nettype none

`include "rotary_encoder_key_events_unit_macros.svh"

module rek_core
  import rek_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire in_item_t  item_i,
  input  wire cfg_t      cfg_i,
  output logic           res_valid_o,
  output out_item_t      res_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_WAITING = 2'd2;
  localparam logic [1:0] PH_BLOCKED = 2'd3;

  logic [15:0] pos_q, pos_d;
  logic        a_prev_q, a_prev_d;
  logic        key_prev_q, key_prev_d;
  logic [7:0]  since_q, since_d;
  logic [15:0] press_q, press_d;
  logic [15:0] release_q, release_d;
  logic [15:0] first_q, first_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        rot_q, rot_d;
  logic [1:0]  phase_q, phase_d;

  logic [7:0]  since_t;
  logic [15:0] press_t, release_t, first_t, first_k, press_k, release_k, delta;
  logic [1:0]  cnt_k, phase_k;
  logic        rot_k, key_chg, stale, step, fast, key;
  ev_code_e    code;

  assign key  = item_i.key_down;
  assign step = item_i.chan_a && !a_prev_q;

  always_comb begin
    // Timers advance first.
    since_t   = (item_i.ms_tick && since_q != 8'hFF) ? since_q + 8'd1 : since_q;
    press_t   = (item_i.ms_tick && key_prev_q) ? sat_inc16(press_q) : press_q;
    release_t = (item_i.ms_tick && phase_q == PH_WAITING) ? sat_inc16(release_q)
                                                          : release_q;
    first_t   = (item_i.ms_tick && first_q != 16'd0) ? sat_inc16(first_q) : first_q;

    // Key change.
    key_chg   = key != key_prev_q;
    stale     = (first_t != 16'd0) && ((first_t - 16'd1) > cfg_i.double_window_ms);
    first_k   = first_t;
    cnt_k     = cnt_q;
    press_k   = press_t;
    release_k = release_t;
    phase_k   = phase_q;
    rot_k     = rot_q;
    if (key_chg) begin
      if (stale) begin
        first_k = 16'd0;
        cnt_k   = 2'd0;
      end
      if (key) begin
        press_k = 16'd0;
        if (phase_q == PH_IDLE) phase_k = PH_PRESSED;
      end else begin
        if (cnt_k != 2'd3) cnt_k = cnt_k + 2'd1;
        if (cnt_k == 2'd1 && first_k == 16'd0) first_k = 16'd1;
        if (phase_q == PH_PRESSED) begin
          phase_k   = PH_WAITING;
          release_k = 16'd0;
        end else if (phase_q == PH_BLOCKED) begin
          phase_k = PH_IDLE;
        end
      end
      rot_k = 1'b0;
    end

    fast = (since_t < cfg_i.fast_window_ms) && !key;
    if (key) begin
      code  = item_i.chan_b ? EV_KEY_CW : EV_KEY_CCW;
      delta = cfg_i.big_step_enable ? cfg_i.big_step : 16'd1;
    end else if (fast) begin
      code  = item_i.chan_b ? EV_FAST_CW : EV_FAST_CCW;
      delta = cfg_i.fast_step;
    end else begin
      code  = item_i.chan_b ? EV_CW : EV_CCW;
      delta = 16'd1;
    end

    pos_d       = pos_q;
    a_prev_d    = item_i.chan_a;
    key_prev_d  = key;
    since_d     = since_t;
    press_d     = press_k;
    release_d   = release_k;
    first_d     = first_k;
    cnt_d       = cnt_k;
    rot_d       = rot_k;
    phase_d     = phase_k;
    res_valid_o = 1'b0;
    res_o       = '{event_code: EV_CW, position: $signed(pos_q), click_ms: 16'd0};

    if (step) begin
      pos_d   = item_i.chan_b ? pos_q + delta : pos_q - delta;
      since_d = 8'd0;
      cnt_d   = 2'd0;
      rot_d   = 1'b1;
      if (phase_k == PH_PRESSED) begin
        phase_d = PH_BLOCKED;
      end else if (phase_k == PH_WAITING) begin
        phase_d = key ? PH_BLOCKED : PH_IDLE;
      end
      res_valid_o = 1'b1;
      res_o       = '{event_code: code, position: $signed(pos_d), click_ms: 16'd0};
    end else begin
      unique case (phase_k)
        PH_PRESSED: begin
          if (key && press_k >= cfg_i.hold_ms) begin
            phase_d     = PH_BLOCKED;
            res_valid_o = 1'b1;
            res_o.event_code = EV_LONG;
            res_o.click_ms   = cfg_i.hold_ms;
          end
        end
        PH_WAITING: begin
          if (release_k >= cfg_i.double_window_ms) begin
            phase_d = key ? PH_PRESSED : PH_IDLE;
            if (cnt_k == 2'd2) begin
              res_valid_o = 1'b1;
              res_o.event_code = EV_DOUBLE;
              res_o.click_ms   = press_k;
            end else if (!key && press_k != 16'd0 && press_k < cfg_i.single_max_ms
                         && !rot_k) begin
              res_valid_o = 1'b1;
              res_o.event_code = EV_SINGLE;
              res_o.click_ms   = press_k;
            end
          end
        end
        PH_IDLE, PH_BLOCKED: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 16'd0;
      a_prev_q   <= 1'b1;
      key_prev_q <= 1'b0;
      since_q    <= 8'hFF;
      press_q    <= 16'd0;
      release_q  <= 16'd0;
      first_q    <= 16'd0;
      cnt_q      <= 2'd0;
      rot_q      <= 1'b0;
      phase_q    <= PH_IDLE;
    end else if (adv_i) begin
      pos_q      <= pos_d;
      a_prev_q   <= a_prev_d;
      key_prev_q <= key_prev_d;
      since_q    <= since_d;
      press_q    <= press_d;
      release_q  <= release_d;
      first_q    <= first_d;
      cnt_q      <= cnt_d;
      rot_q      <= rot_d;
      phase_q    <= phase_d;
    end
  end

  `REK_ASSERT(a_rot_no_ms,
              res_valid_o && step |-> res_o.click_ms == 16'd0,
              "rotation with click time")
  `REK_ASSERT(a_step_clears_timer,
              adv_i && step |=> since_q == 8'd0 && cnt_q == 2'd0,
              "step did not clear timers")
  `REK_ASSERT(a_long_blocks,
              adv_i && res_valid_o && res_o.event_code == EV_LONG |=> phase_q == PH_BLOCKED,
              "long click not blocked")
  `REK_ASSERT(a_pos_only_on_step,
              !(adv_i && step) |=> $stable(pos_q),
              "position moved without step")

endmodule

`default_nettype wire

@@ hw/rtl/rek_out_reg.sv @@
`default_nettype none

module rek_out_reg
  import rek_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire out_item_t item_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  // The register can take a new result when empty or when its transaction completes now.
  assign free_o      = !valid_q || !out_stall_i;
  assign valid_d     = free_o ? load_i : valid_q;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rotary_encoder_key_events_unit.sv @@
// Path: a sample is captured in the input register; its result is then captured in the result
// register, from which the output side can take it.
// Throughput: one sample per cycle, set by the combinational update of the encoder and
// click state between those two registers; stall on the output holds the input side.
// Reset: rst_ni is asynchronous and active low; it restores the register defaults and the
// encoder and click state (step timer saturated, channel A high) and empties both registers.
`default_nettype none

module rotary_encoder_key_events_unit
  import rek_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg_q;
  in_item_t  in_q;
  logic      in_valid_q;
  logic      adv, out_free, res_valid;
  out_item_t res;

  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAST_STEP:     cfg_q.fast_step        <= cfg_wdata_i;
        CFG_BIG_STEP:      cfg_q.big_step         <= cfg_wdata_i;
        CFG_BIG_STEP_EN:   cfg_q.big_step_enable  <= cfg_wdata_i[0];
        CFG_FAST_WINDOW:   cfg_q.fast_window_ms   <= cfg_wdata_i[7:0];
        CFG_HOLD:          cfg_q.hold_ms          <= cfg_wdata_i;
        CFG_DOUBLE_WINDOW: cfg_q.double_window_ms <= cfg_wdata_i;
        CFG_SINGLE_MAX:    cfg_q.single_max_ms    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rek_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (in_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rek_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && res_valid),
    .item_i      (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
